>>> rtl/bcd_pkg.sv
package bcd_pkg;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam int WIDTH_BITS   = 13;
    localparam int HEIGHT_BITS  = 16;
    localparam int PATTERN_BITS = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // Quotient bits that the divide-by-three unit resolves per cycle while i_step is high.
    localparam int DIV3_STEP_BITS = 9;

    localparam logic [WIDTH_BITS-1:0]   RST_FRAME_WIDTH  = 13'd4096;
    localparam logic [HEIGHT_BITS-1:0]  RST_FRAME_HEIGHT = 16'd1;
    localparam logic [PATTERN_BITS-1:0] RST_CFA_PATTERN  = 8'd148;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_CFA_PATTERN  = 2'd2
    } t_cfg_idx;

    // Classification that the front end attaches to each queued item.
    typedef struct packed {
        logic emit;
        logic last;
    } t_job_ctl;

endpackage

>>> rtl/bcd_front.sv
module bcd_front #(
    parameter int MAX_WIDTH   = bcd_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = bcd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       i_width,
    input  logic [bcd_pkg::HEIGHT_BITS-1:0]      i_height,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_func,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic                                 i_sample_valid,
    output logic                                 o_push,
    input  logic                                 i_full,
    output logic [SAMPLE_BITS:0]                 o_entry,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_addr,
    output bcd_pkg::t_job_ctl                    o_ctl
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = bcd_pkg::HEIGHT_BITS + 1;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          in_frame;
    logic          drop;
    logic [WW-1:0] col_inc;
    logic          col_wrap;

    always_comb begin
        o_ready  = !i_full;
        in_frame = r_row < RW'(i_height);
        // A drain item inside the frame carries nothing and is dropped here.
        drop     = in_frame && i_func;
        o_push   = i_valid && o_ready && !drop;
        o_entry  = (in_frame && i_sample_valid) ? {1'b1, i_sample} : '0;
        o_addr   = r_col;
        o_ctl.emit = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (r_col != '0));
        // The item that yields the frame's last pixel sits one row past the
        // frame's end, in column zero.
        o_ctl.last = (r_row == (RW'(i_height) + RW'(1))) && (r_col == '0);
        col_inc  = WW'(r_col) + WW'(1);
        col_wrap = col_inc >= i_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            if (o_ctl.last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (col_wrap) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= CW'(col_inc);
            end
        end
    end

endmodule

>>> rtl/bcd_queue.sv
module bcd_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);

    logic [DW-1:0] r_mem [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");
`endif

endmodule

>>> rtl/bcd_div3.sv
module bcd_div3 #(
    parameter int NB = 34
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic [NB-1:0] i_num,
    input  logic          i_step,
    output logic [NB-1:0] o_num
);

    localparam int SBITS = bcd_pkg::DIV3_STEP_BITS;
    localparam int STEPS = (NB + SBITS - 1) / SBITS;
    localparam int PW    = STEPS * SBITS;

    logic [PW-1:0]    r_num;
    logic [1:0]       r_rem;
    logic [1:0]       rem;
    logic [2:0]       trial;
    logic [SBITS-1:0] qbits;

    // Long division by three, SBITS quotient bits per step. Each bit is a
    // compare and subtract on a 3-bit partial remainder. After STEPS steps
    // the shift register holds the quotient.
    always_comb begin
        rem   = r_rem;
        trial = '0;
        for (int j = 0; j < SBITS; j++) begin
            trial = {rem, r_num[PW-1-j]};
            qbits[SBITS-1-j] = trial >= 3'd3;
            rem = (trial >= 3'd3) ? 2'(trial - 3'd3) : 2'(trial);
        end
        o_num = r_num[NB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_num <= PW'(i_num);
            r_rem <= 2'd0;
        end else if (i_step) begin
            r_num <= {r_num[PW-SBITS-1:0], qbits};
            r_rem <= rem;
        end
    end

endmodule

>>> rtl/bcd_back.sv
module bcd_back #(
    parameter int MAX_WIDTH   = bcd_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = bcd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_restart,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       i_width,
    input  logic [bcd_pkg::HEIGHT_BITS-1:0]      i_height,
    input  logic [bcd_pkg::PATTERN_BITS-1:0]     i_pattern,
    input  logic                                 i_empty,
    input  logic [SAMPLE_BITS:0]                 i_entry,
    input  logic [$clog2(MAX_WIDTH)-1:0]         i_addr,
    input  bcd_pkg::t_job_ctl                    i_ctl,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [2:0][SAMPLE_BITS-1:0]          o_value,
    output logic [2:0]                           o_ok,
    output logic                                 o_frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int SB  = SAMPLE_BITS;
    localparam int NB  = SAMPLE_BITS + 2;
    localparam int DIV_STEPS = (NB + bcd_pkg::DIV3_STEP_BITS - 1) / bcd_pkg::DIV3_STEP_BITS;
    localparam int DCW = $clog2(DIV_STEPS);
    localparam int HB  = bcd_pkg::HEIGHT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SUM,
        S_NORM,
        S_DIV,
        S_FIN
    } t_state;

    function automatic logic [1:0] chan_code(input logic [bcd_pkg::PATTERN_BITS-1:0] pat,
                                             input logic y_odd, input logic x_odd);
        logic [1:0] code;
        case ({y_odd, x_odd})
            2'b00:   code = pat[1:0];
            2'b01:   code = pat[3:2];
            2'b10:   code = pat[5:4];
            default: code = pat[7:6];
        endcase
        return code;
    endfunction

    function automatic logic signed [NB-1:0] sx(input logic [SB:0] e);
        logic signed [SB-1:0] v;
        v = e[SB-1:0];
        return NB'(v);
    endfunction

    t_state              r_state;
    logic [SB:0]         r_upper [MAX_WIDTH];
    logic [SB:0]         r_middle [MAX_WIDTH];
    logic [SB:0]         r_top;
    logic [SB:0]         r_mid;
    logic [SB:0]         r_win [9];
    logic [SB:0]         r_job_entry;
    logic [CW-1:0]       r_job_addr;
    bcd_pkg::t_job_ctl   r_job_ctl;
    logic [CW-1:0]       r_out_col;
    logic [HB-1:0]       r_out_row;
    logic signed [NB-1:0] r_sum [3];
    logic [2:0]          r_cnt [3];
    logic [2:0]          r_neg;
    logic [DCW-1:0]      r_div_cnt;
    logic                r_out_valid;
    logic [2:0][SB-1:0]  r_out_value;
    logic [2:0]          r_out_ok;
    logic                r_out_last;

    logic                wr_en;
    logic                fin_load;
    logic                x_first, x_last, y_first, y_last;
    logic                px, pxl, pxr, py, pyu, pyd;
    logic [SB:0]         c_l, c_r, c_u, c_d, c_ul, c_ur, c_dl, c_dr;
    logic [1:0]          ch_own, ch_l, ch_r, ch_u, ch_d, ch_ul, ch_ur, ch_dl, ch_dr;
    logic signed [NB-1:0] s_sum [3];
    logic [2:0]          s_cnt [3];
    logic [NB-1:0]       s_num [3];
    logic [NB-1:0]       d_num [3];
    logic [2:0][SB-1:0]  f_value;
    logic [2:0]          f_ok;
    logic                any_three;

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign wr_en       = r_state == S_LOAD;
    assign fin_load    = (r_state == S_FIN) && (!r_out_valid || i_ready);
    assign o_valid     = r_out_valid;
    assign o_value     = r_out_value;
    assign o_ok        = r_out_ok;
    assign o_frame_end = r_out_last;

    // Line stores: read when an item leaves the queue, rewritten in the next cycle (S_LOAD).
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_top <= r_upper[i_addr];
            r_mid <= r_middle[i_addr];
        end
        if (wr_en) begin
            r_upper[r_job_addr]  <= r_mid;
            r_middle[r_job_addr] <= r_job_entry;
        end
    end

    // Neighbor selection with clamping at the frame borders.
    always_comb begin
        x_first = r_out_col == '0;
        x_last  = (WW'(r_out_col) + WW'(1)) >= i_width;
        y_first = r_out_row == '0;
        y_last  = ({1'b0, r_out_row} + (HB+1)'(1)) >= {1'b0, i_height};

        c_l  = x_first ? r_win[4] : r_win[3];
        c_r  = x_last  ? r_win[4] : r_win[5];
        c_u  = y_first ? r_win[4] : r_win[1];
        c_d  = y_last  ? r_win[4] : r_win[7];
        c_ul = y_first ? (x_first ? r_win[4] : r_win[3]) : (x_first ? r_win[1] : r_win[0]);
        c_ur = y_first ? (x_last  ? r_win[4] : r_win[5]) : (x_last  ? r_win[1] : r_win[2]);
        c_dl = y_last  ? (x_first ? r_win[4] : r_win[3]) : (x_first ? r_win[7] : r_win[6]);
        c_dr = y_last  ? (x_last  ? r_win[4] : r_win[5]) : (x_last  ? r_win[7] : r_win[8]);

        px  = r_out_col[0];
        py  = r_out_row[0];
        pxl = x_first ? px : !px;
        pxr = x_last  ? px : !px;
        pyu = y_first ? py : !py;
        pyd = y_last  ? py : !py;

        ch_own = chan_code(i_pattern, py, px);
        ch_l   = chan_code(i_pattern, py, pxl);
        ch_r   = chan_code(i_pattern, py, pxr);
        ch_u   = chan_code(i_pattern, pyu, px);
        ch_d   = chan_code(i_pattern, pyd, px);
        ch_ul  = chan_code(i_pattern, pyu, pxl);
        ch_ur  = chan_code(i_pattern, pyu, pxr);
        ch_dl  = chan_code(i_pattern, pyd, pxl);
        ch_dr  = chan_code(i_pattern, pyd, pxr);
    end

    always_comb begin
        logic                 t_own, t_l, t_r, t_u, t_d, t_ul, t_ur, t_dl, t_dr;
        logic signed [NB-1:0] e_sum, g_sum;
        logic [2:0]           e_cnt, g_cnt;
        logic [NB-1:0]        mag;
        logic [NB-1:0]        rnd;
        logic [NB-1:0]        q;
        logic [NB-1:0]        v;
        for (int p = 0; p < 3; p++) begin
            t_own = (ch_own == 2'(p)) && r_win[4][SB];
            t_l   = (ch_l  == 2'(p)) && c_l[SB];
            t_r   = (ch_r  == 2'(p)) && c_r[SB];
            t_u   = (ch_u  == 2'(p)) && c_u[SB];
            t_d   = (ch_d  == 2'(p)) && c_d[SB];
            t_ul  = (ch_ul == 2'(p)) && c_ul[SB];
            t_ur  = (ch_ur == 2'(p)) && c_ur[SB];
            t_dl  = (ch_dl == 2'(p)) && c_dl[SB];
            t_dr  = (ch_dr == 2'(p)) && c_dr[SB];
            e_sum = (t_l ? sx(c_l) : '0) + (t_r ? sx(c_r) : '0)
                  + (t_u ? sx(c_u) : '0) + (t_d ? sx(c_d) : '0);
            e_cnt = 3'(t_l) + 3'(t_r) + 3'(t_u) + 3'(t_d);
            g_sum = (t_ul ? sx(c_ul) : '0) + (t_ur ? sx(c_ur) : '0)
                  + (t_dl ? sx(c_dl) : '0) + (t_dr ? sx(c_dr) : '0);
            g_cnt = 3'(t_ul) + 3'(t_ur) + 3'(t_dl) + 3'(t_dr);
            // A known own sample is a mean over one element.
            if (t_own) begin
                s_sum[p] = sx(r_win[4]);
                s_cnt[p] = 3'd1;
            end else if (e_cnt != 3'd0) begin
                s_sum[p] = e_sum;
                s_cnt[p] = e_cnt;
            end else begin
                s_sum[p] = g_sum;
                s_cnt[p] = g_cnt;
            end

            // Magnitude plus half the divisor, then divide and restore the sign.
            mag = r_sum[p][NB-1] ? NB'(-r_sum[p]) : NB'(r_sum[p]);
            case (r_cnt[p])
                3'd2:    rnd = NB'(1);
                3'd3:    rnd = NB'(1);
                3'd4:    rnd = NB'(2);
                default: rnd = '0;
            endcase
            s_num[p] = mag + rnd;

            case (r_cnt[p])
                3'd2:    q = d_num[p] >> 1;
                3'd4:    q = d_num[p] >> 2;
                default: q = d_num[p];
            endcase
            v = r_neg[p] ? NB'(-q) : q;
            f_ok[p]    = r_cnt[p] != 3'd0;
            f_value[p] = f_ok[p] ? v[SB-1:0] : '0;
        end
        any_three = (r_cnt[0] == 3'd3) || (r_cnt[1] == 3'd3) || (r_cnt[2] == 3'd3);
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        bcd_div3 #(
            .NB(NB)
        ) u_div (
            .i_clk  (i_clk),
            .i_load (r_state == S_NORM),
            .i_num  (s_num[g]),
            .i_step ((r_state == S_DIV) && (r_cnt[g] == 3'd3)),
            .o_num  (d_num[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_div_cnt   <= '0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (r_out_valid && i_ready && !fin_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_job_entry <= i_entry;
                        r_job_addr  <= i_addr;
                        r_job_ctl   <= i_ctl;
                        r_state     <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_win[0] <= r_win[1];
                    r_win[1] <= r_win[2];
                    r_win[2] <= r_top;
                    r_win[3] <= r_win[4];
                    r_win[4] <= r_win[5];
                    r_win[5] <= r_mid;
                    r_win[6] <= r_win[7];
                    r_win[7] <= r_win[8];
                    r_win[8] <= r_job_entry;
                    r_state  <= r_job_ctl.emit ? S_SUM : S_IDLE;
                end
                S_SUM: begin
                    for (int p = 0; p < 3; p++) begin
                        r_sum[p] <= s_sum[p];
                        r_cnt[p] <= s_cnt[p];
                    end
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    for (int p = 0; p < 3; p++) begin
                        r_neg[p] <= r_sum[p][NB-1];
                    end
                    r_div_cnt <= '0;
                    r_state   <= any_three ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (r_div_cnt == DCW'(DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_div_cnt <= r_div_cnt + DCW'(1);
                    end
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= f_value;
                        r_out_ok    <= f_ok;
                        r_out_last  <= r_job_ctl.last;
                        if (r_job_ctl.last || i_restart) begin
                            r_out_col <= '0;
                            r_out_row <= '0;
                        end else if (x_last) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + HB'(1);
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (i_restart && !fin_load) begin
                r_out_col <= '0;
                r_out_row <= '0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_load && r_job_ctl.last) |=> (r_out_col == '0 && r_out_row == '0))
        else $error("output position not reset after the last pixel");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_ok[0] || o_value[0] == '0) && (o_ok[1] || o_value[1] == '0)
                     && (o_ok[2] || o_value[2] == '0)))
        else $error("invalid plane carries a nonzero value");
`endif

endmodule

>>> rtl/bilinear_cfa_demosaic_top.sv
// An item that yields a pixel passes the back-end states S_IDLE, S_LOAD, S_SUM, S_NORM,
// S_DIV (only when a plane averages three) and S_FIN, which registers the pixel.
// The back-end sequencer pops one item at a time, only in S_IDLE; an item that yields
// no pixel returns there from S_LOAD. In-frame drain items are dropped at the front.
// Pixels come out one row plus one pixel behind the input stream.
// Reset (synchronous, active low) clears positions, queue and window and loads
// width 4096, height 1, pattern 148; the line stores are not cleared.
module bilinear_cfa_demosaic_top #(
    parameter int MAX_WIDTH   = bcd_pkg::DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = bcd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_func,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic                                 i_sample_valid,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]        o_plane0_value,
    output logic                                 o_plane0_ok,
    output logic signed [SAMPLE_BITS-1:0]        o_plane1_value,
    output logic                                 o_plane1_ok,
    output logic signed [SAMPLE_BITS-1:0]        o_plane2_value,
    output logic                                 o_plane2_ok,
    output logic                                 o_frame_end,
    input  logic                                 i_cfg_we,
    input  logic [bcd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [bcd_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > bcd_pkg::WIDTH_BITS) ? WW : bcd_pkg::WIDTH_BITS;
    localparam int SB = SAMPLE_BITS;
    localparam int QW = $bits(bcd_pkg::t_job_ctl) + CW + SB + 1;

    logic [bcd_pkg::WIDTH_BITS-1:0]   r_frame_width;
    logic [bcd_pkg::HEIGHT_BITS-1:0]  r_frame_height;
    logic [bcd_pkg::PATTERN_BITS-1:0] r_cfa_pattern;

    logic                             restart;
    logic [EW-1:0]                    width_ext;
    logic [EW-1:0]                    width_clamp;
    logic [WW-1:0]                    eff_width;
    logic [bcd_pkg::HEIGHT_BITS-1:0]  eff_height;

    logic                             f_push;
    logic [SB:0]                      f_entry;
    logic [CW-1:0]                    f_addr;
    bcd_pkg::t_job_ctl                f_ctl;
    logic                             q_full;
    logic                             q_empty;
    logic                             q_pop;
    logic [QW-1:0]                    q_data;
    logic [SB:0]                      q_entry;
    logic [CW-1:0]                    q_addr;
    bcd_pkg::t_job_ctl                q_ctl;
    logic [2:0][SB-1:0]               b_value;
    logic [2:0]                       b_ok;

    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            case (bcd_pkg::t_cfg_idx'(i_cfg_index))
                bcd_pkg::CFG_FRAME_WIDTH:  restart = 1'b1;
                bcd_pkg::CFG_FRAME_HEIGHT: restart = 1'b1;
                bcd_pkg::CFG_CFA_PATTERN:  restart = 1'b1;
                default:                   restart = 1'b0;
            endcase
        end
        width_ext = EW'(r_frame_width);
        if (width_ext == '0) begin
            width_clamp = EW'(1);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            width_clamp = EW'(MAX_WIDTH);
        end else begin
            width_clamp = width_ext;
        end
        eff_width  = WW'(width_clamp);
        eff_height = (r_frame_height == '0) ? bcd_pkg::HEIGHT_BITS'(1) : r_frame_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bcd_pkg::RST_FRAME_WIDTH;
            r_frame_height <= bcd_pkg::RST_FRAME_HEIGHT;
            r_cfa_pattern  <= bcd_pkg::RST_CFA_PATTERN;
        end else if (i_cfg_we) begin
            case (bcd_pkg::t_cfg_idx'(i_cfg_index))
                bcd_pkg::CFG_FRAME_WIDTH:
                    r_frame_width <= i_cfg_data[bcd_pkg::WIDTH_BITS-1:0];
                bcd_pkg::CFG_FRAME_HEIGHT:
                    r_frame_height <= i_cfg_data[bcd_pkg::HEIGHT_BITS-1:0];
                bcd_pkg::CFG_CFA_PATTERN:
                    r_cfa_pattern <= i_cfg_data[bcd_pkg::PATTERN_BITS-1:0];
                default: ;
            endcase
        end
    end

    bcd_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (restart),
        .i_width        (eff_width),
        .i_height       (eff_height),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_func         (i_func),
        .i_sample       (i_sample),
        .i_sample_valid (i_sample_valid),
        .o_push         (f_push),
        .i_full         (q_full),
        .o_entry        (f_entry),
        .o_addr         (f_addr),
        .o_ctl          (f_ctl)
    );

    bcd_queue #(
        .DW (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_addr, f_entry}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign q_entry = q_data[SB:0];
    assign q_addr  = q_data[SB+CW:SB+1];
    assign q_ctl   = bcd_pkg::t_job_ctl'(q_data[QW-1:SB+CW+1]);

    bcd_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_width     (eff_width),
        .i_height    (eff_height),
        .i_pattern   (r_cfa_pattern),
        .i_empty     (q_empty),
        .i_entry     (q_entry),
        .i_addr      (q_addr),
        .i_ctl       (q_ctl),
        .o_pop       (q_pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_value     (b_value),
        .o_ok        (b_ok),
        .o_frame_end (o_frame_end)
    );

    assign o_plane0_value = b_value[0];
    assign o_plane1_value = b_value[1];
    assign o_plane2_value = b_value[2];
    assign o_plane0_ok    = b_ok[0];
    assign o_plane1_ok    = b_ok[1];
    assign o_plane2_ok    = b_ok[2];

endmodule
